/* rtl/rfpv_pkg.sv */
// Shared types and constants for the record file parse and verify block.
package rfpv_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned ROLE_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 64;

    localparam logic [WORD_W-1:0]  MAGIC_RST   = 32'h4249_4E31;
    localparam logic [BYTE_W-1:0]  VERSION_RST = 8'd1;
    localparam logic [COUNT_W-1:0] MAX_REC_RST = 16'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REC = 2'd2;

    // byte role codes
    localparam logic [ROLE_W-1:0] ROLE_NONE    = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_HEADER  = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_ID      = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_LEN     = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_NAME    = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_GRADE   = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_IGNORED = 3'd6;

    // parse status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0]  magic;
        logic [BYTE_W-1:0]  version;
        logic [COUNT_W-1:0] max_rec;
    } cfg_t;

    typedef struct packed {
        logic [ROLE_W-1:0]   role;
        logic [COUNT_W-1:0]  recno;
        logic [STATUS_W-1:0] verdict;
    } parse_res_t;

endpackage

/* rtl/rfpv_parser.sv */
// Header and record field parser: tags each released byte and tracks file status.
module rfpv_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       clr,
    input  logic [rfpv_pkg::BYTE_W-1:0] data_byte,
    input  rfpv_pkg::cfg_t             cfg,
    output rfpv_pkg::parse_res_t       res
);
    import rfpv_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_LEN,
        PH_NAME,
        PH_GRADE,
        PH_DONE,
        PH_REJECT
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [3:0]          pos_reg, pos_next;
    logic [WORD_W-1:0]   gather_reg, gather_next;
    logic                hdr_bad_reg, hdr_bad_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0]   name_left_reg, name_left_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    logic [1:0]          lane;
    logic [WORD_W-1:0]   lane_word;
    logic [WORD_W-1:0]   name_dec;
    logic [COUNT_W-1:0]  left_dec;
    logic [ROLE_W-1:0]   role;

    // count bytes sit at header positions 5..8, lanes 0..3
    assign lane = (phase_reg == PH_HEADER && pos_reg > 4'd4) ? (pos_reg[1:0] - 2'd1)
                                                              : pos_reg[1:0];
    assign lane_word = {{(WORD_W-BYTE_W){1'b0}}, data_byte} << {lane, 3'b000};
    assign name_dec  = name_left_reg - 32'd1;
    assign left_dec  = left_reg - 16'd1;

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        gather_next    = gather_reg;
        hdr_bad_next   = hdr_bad_reg;
        left_next      = left_reg;
        cnt_next       = cnt_reg;
        name_left_next = name_left_reg;
        err_next       = err_reg;
        role           = ROLE_NONE;
        if (en) begin
            case (phase_reg)
                PH_HEADER: begin
                    role = ROLE_HEADER;
                    if (pos_reg != 4'd4) begin
                        gather_next = gather_reg | lane_word;
                    end
                    if (pos_reg == 4'd3) begin
                        if (gather_next != cfg.magic) begin
                            hdr_bad_next = 1'b1;
                        end
                        gather_next = '0;
                    end
                    if (pos_reg == 4'd4 && data_byte != cfg.version) begin
                        hdr_bad_next = 1'b1;
                    end
                    if (pos_reg >= 4'd8) begin
                        pos_next = '0;
                        if (hdr_bad_next) begin
                            err_next   = ST_BAD_HDR;
                            phase_next = PH_REJECT;
                        end else if (gather_next > {{(WORD_W-COUNT_W){1'b0}}, cfg.max_rec}) begin
                            err_next   = ST_TOO_MANY;
                            phase_next = PH_REJECT;
                        end else begin
                            left_next  = gather_next[COUNT_W-1:0];
                            phase_next = (gather_next[COUNT_W-1:0] != '0) ? PH_ID : PH_DONE;
                        end
                        gather_next = '0;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_ID: begin
                    role = ROLE_ID;
                    if (pos_reg >= 4'd3) begin
                        pos_next    = '0;
                        gather_next = '0;
                        phase_next  = PH_LEN;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_LEN: begin
                    role        = ROLE_LEN;
                    gather_next = gather_reg | lane_word;
                    if (pos_reg >= 4'd3) begin
                        name_left_next = gather_next;
                        phase_next     = (gather_next != '0) ? PH_NAME : PH_GRADE;
                        gather_next    = '0;
                        pos_next       = '0;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_NAME: begin
                    role           = ROLE_NAME;
                    name_left_next = name_dec;
                    if (name_dec == '0) begin
                        pos_next   = '0;
                        phase_next = PH_GRADE;
                    end
                end
                PH_GRADE: begin
                    role = ROLE_GRADE;
                    if (pos_reg >= 4'd7) begin
                        pos_next   = '0;
                        cnt_next   = cnt_reg + 16'd1;
                        left_next  = left_dec;
                        phase_next = (left_dec != '0) ? PH_ID : PH_DONE;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                default: begin
                    role = ROLE_IGNORED;
                end
            endcase
        end
    end

    always_comb begin
        res.role  = role;
        res.recno = en ? cnt_reg : '0;
        if (err_next != ST_OK) begin
            res.verdict = err_next;
        end else if (phase_next == PH_DONE) begin
            res.verdict = ST_OK;
        end else begin
            res.verdict = ST_TRUNCATED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            gather_reg    <= '0;
            hdr_bad_reg   <= 1'b0;
            left_reg      <= '0;
            cnt_reg       <= '0;
            name_left_reg <= '0;
            err_reg       <= ST_OK;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            gather_reg    <= gather_next;
            hdr_bad_reg   <= hdr_bad_next;
            left_reg      <= left_next;
            cnt_reg       <= cnt_next;
            name_left_reg <= name_left_next;
            err_reg       <= err_next;
        end
    end

endmodule

/* rtl/record_file_parse_verify_top.sv */
// Top level: checksum tail delay, byte sum, parser and result register.
//
// Channel   Dir  tdata                                  tuser       tlast
// s_        in   file_byte                              -           final_byte
// m_        out  released_byte, record_number, status,  byte_role   file_done
//                sum_matches, computed_sum
//
// One byte request is taken every cycle while s_tready is high; its result is
// captured in the output register and appears in the cycle after it is taken.
// s_tready drops only while a result waits in the output register.
// aresetn is synchronous; configuration returns to its defaults. The parse
// state also clears after each final byte.
module record_file_parse_verify_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rfpv_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [rfpv_pkg::WORD_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rfpv_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] file_byte
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] released_byte, [23:8] record_number, [25:24] parse_status,
    // [26] sum_matches, [58:27] computed_sum, [63:59] zero
    output logic [rfpv_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [rfpv_pkg::ROLE_W-1:0]     m_tuser,  // [2:0] byte_role
    output logic                            m_tlast
);
    import rfpv_pkg::*;

    cfg_t               cfg_reg;
    logic [BYTE_W-1:0]  tail_reg [4];
    logic [BYTE_W-1:0]  tail_next [4];
    logic [2:0]         fill_reg, fill_next;
    logic [WORD_W-1:0]  sum_reg, sum_next;

    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [ROLE_W-1:0]   m_user_reg;
    logic                m_last_reg;

    logic               accept;
    logic               release_en;
    logic               clr;
    logic [BYTE_W-1:0]  rel_byte;
    logic [WORD_W-1:0]  stored;
    logic               match;
    logic [STATUS_W-1:0] status;
    parse_res_t         pres;

    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign release_en = accept && fill_reg[2];
    assign clr        = accept && s_tlast;
    assign rel_byte   = release_en ? tail_reg[0] : '0;

    rfpv_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (release_en),
        .clr       (clr),
        .data_byte (tail_reg[0]),
        .cfg       (cfg_reg),
        .res       (pres)
    );

    always_comb begin
        tail_next = tail_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (accept) begin
            if (fill_reg[2]) begin
                tail_next[0] = tail_reg[1];
                tail_next[1] = tail_reg[2];
                tail_next[2] = tail_reg[3];
                tail_next[3] = s_tdata[BYTE_W-1:0];
                sum_next     = sum_reg + {{(WORD_W-BYTE_W){1'b0}}, tail_reg[0]};
            end else begin
                tail_next[fill_reg[1:0]] = s_tdata[BYTE_W-1:0];
                fill_next                = fill_reg + 3'd1;
            end
        end
    end

    // little-endian checksum held in the delay after this byte
    assign stored = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};

    always_comb begin
        match  = 1'b0;
        status = ST_OK;
        if (s_tlast) begin
            if (!fill_next[2]) begin
                status = ST_TRUNCATED;
            end else begin
                match  = (stored == sum_next);
                status = pres.verdict;
            end
        end
        m_data_next = {5'd0, sum_next, match, status, pres.recno, rel_byte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{magic: MAGIC_RST, version: VERSION_RST, max_rec: MAX_REC_RST};
        end else if (cfg_we) begin
            case (cfg_idx)
                CFG_MAGIC:   cfg_reg.magic   <= cfg_wdata;
                CFG_VERSION: cfg_reg.version <= cfg_wdata[BYTE_W-1:0];
                CFG_MAX_REC: cfg_reg.max_rec <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            for (int i = 0; i < 4; i++) begin
                tail_reg[i] <= '0;
            end
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= pres.role;
            m_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/rfpv_checker.sv */
// Port-level checks for the record file parse and verify block, with bind.
module rfpv_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rfpv_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [rfpv_pkg::ROLE_W-1:0]     m_tuser,
    input logic                            m_tlast
);
    import rfpv_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // status and match flag are only reported on the final byte
    a_status_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[26:24] == 3'd0)
        else $error("status reported before final byte");

    // no released byte means no data and no record index
    a_none_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ROLE_NONE |-> m_tdata[23:0] == 24'd0)
        else $error("empty result carries data");

    // an accepted input always yields a result next cycle
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted byte produced no result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind record_file_parse_verify_top rfpv_checker u_rfpv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* bench/tb_record_file_parse_verify_top.sv */
// Self-checking bench for the record file parser: stream stimulus, byte-level prediction.
module tb_record_file_parse_verify_top;
    import rfpv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_PER_SET  = 350;

    typedef enum logic [2:0] {
        HDR, REC_ID, REC_LEN, REC_NAME, REC_GRADE, ALL_DONE, REJECTED
    } parse_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_beat_t;

    typedef struct {
        logic [ROLE_W-1:0]   role;
        logic [7:0]          data;
        logic [15:0]         recno;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic                match;
        logic [31:0]         sum;
    } release_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [WORD_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [ROLE_W-1:0]     m_tuser;
    logic                  m_tlast;

    record_file_parse_verify_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // register copies seen by the predictor and the file builder
    logic [31:0] exp_magic   = MAGIC_RST;
    logic [7:0]  exp_version = VERSION_RST;
    logic [15:0] rec_limit   = MAX_REC_RST;

    // parser state
    logic [7:0]   tail_q [4];
    int unsigned  tail_cnt;
    logic [31:0]  run_sum;
    parse_phase_e phase;
    logic [3:0]   fpos;
    logic [31:0]  gather;
    logic         hdr_bad;
    logic [15:0]  recs_left;
    logic [15:0]  recs_done;
    logic [31:0]  name_left;
    logic [1:0]   fail_code;

    file_beat_t  pending [$];
    release_t    release_q [$];
    logic [7:0]  fbody [$];
    int unsigned n_queued = 0;
    int unsigned n_in_acc = 0;
    int unsigned n_err    = 0;
    logic        in_taken = 1'b0;
    int unsigned hold_cnt = 0;
    logic        hold_done = 1'b0;
    int unsigned idle_cyc = 0;

    function automatic void clear_parser();
        for (int i = 0; i < 4; i++) tail_q[i] = 8'd0;
        tail_cnt  = 0;
        run_sum   = 32'd0;
        phase     = HDR;
        fpos      = 4'd0;
        gather    = 32'd0;
        hdr_bad   = 1'b0;
        recs_left = 16'd0;
        recs_done = 16'd0;
        name_left = 32'd0;
        fail_code = ST_OK;
    endfunction

    function automatic logic [ROLE_W-1:0] classify_byte(input logic [7:0] b);
        logic [31:0] bw;
        bw = {24'd0, b};
        case (phase)
            HDR: begin
                if (fpos < 4) begin
                    gather |= bw << (8 * fpos);
                    if (fpos == 3) begin
                        if (gather != exp_magic) hdr_bad = 1'b1;
                        gather = 32'd0;
                    end
                end else if (fpos == 4) begin
                    if (b != exp_version) hdr_bad = 1'b1;
                end else begin
                    gather |= bw << (8 * ((fpos - 5) & 3));
                end
                if (fpos >= 8) begin
                    fpos = 4'd0;
                    if (hdr_bad) begin
                        fail_code = ST_BAD_HDR;
                        phase = REJECTED;
                    end else if (gather > {16'd0, rec_limit}) begin
                        fail_code = ST_TOO_MANY;
                        phase = REJECTED;
                    end else begin
                        recs_left = gather[15:0];
                        phase = (recs_left != 0) ? REC_ID : ALL_DONE;
                    end
                    gather = 32'd0;
                end else begin
                    fpos++;
                end
                return ROLE_HEADER;
            end
            REC_ID: begin
                if (fpos >= 3) begin
                    fpos = 4'd0;
                    gather = 32'd0;
                    phase = REC_LEN;
                end else begin
                    fpos++;
                end
                return ROLE_ID;
            end
            REC_LEN: begin
                gather |= bw << (8 * (fpos & 3));
                if (fpos >= 3) begin
                    name_left = gather;
                    gather = 32'd0;
                    fpos = 4'd0;
                    phase = (name_left != 0) ? REC_NAME : REC_GRADE;
                end else begin
                    fpos++;
                end
                return ROLE_LEN;
            end
            REC_NAME: begin
                name_left--;
                if (name_left == 0) begin
                    fpos = 4'd0;
                    phase = REC_GRADE;
                end
                return ROLE_NAME;
            end
            REC_GRADE: begin
                if (fpos >= 7) begin
                    fpos = 4'd0;
                    recs_done++;
                    recs_left--;
                    phase = (recs_left != 0) ? REC_ID : ALL_DONE;
                end else begin
                    fpos++;
                end
                return ROLE_GRADE;
            end
            default: return ROLE_IGNORED;
        endcase
    endfunction

    function automatic void predict_release(input logic [7:0] b, input logic fin,
                                            output release_t r);
        logic [7:0]  rel;
        logic [31:0] stored;
        r = '{role: ROLE_NONE, data: 8'd0, recno: 16'd0, done: fin,
              status: ST_OK, match: 1'b0, sum: 32'd0};
        if (tail_cnt >= 4) begin
            rel = tail_q[0];
            tail_q[0] = tail_q[1];
            tail_q[1] = tail_q[2];
            tail_q[2] = tail_q[3];
            tail_q[3] = b;
            run_sum += {24'd0, rel};
            r.recno = recs_done;
            r.data  = rel;
            r.role  = classify_byte(rel);
        end else begin
            tail_q[tail_cnt] = b;
            tail_cnt++;
        end
        r.sum = run_sum;
        if (fin) begin
            if (tail_cnt < 4) begin
                r.status = ST_TRUNCATED;
            end else begin
                stored  = {tail_q[3], tail_q[2], tail_q[1], tail_q[0]};
                r.match = (stored == run_sum);
                if (fail_code != ST_OK) r.status = fail_code;
                else if (phase == ALL_DONE) r.status = ST_OK;
                else r.status = ST_TRUNCATED;
            end
            clear_parser();
        end
    endfunction

    // ---------------- file builder ----------------
    function automatic void append_byte(input logic [7:0] b);
        fbody.insert(fbody.size(), b);
    endfunction

    function automatic void put_le32(input logic [31:0] w);
        for (int i = 0; i < 4; i++) append_byte(w[8*i +: 8]);
    endfunction

    function automatic void put_noise(input int n);
        repeat (n) append_byte(8'($urandom));
    endfunction

    function automatic void put_header(input logic [31:0] mg, input logic [7:0] ver,
                                       input logic [31:0] cnt);
        put_le32(mg);
        append_byte(ver);
        put_le32(cnt);
    endfunction

    function automatic void put_record();
        int len;
        len = ($urandom_range(4) == 0) ? $urandom_range(24) : $urandom_range(4);
        put_noise(4);
        put_le32(32'(len));
        put_noise(len);
        put_noise(8);
    endfunction

    // send the body as one file, last byte flagged
    function automatic void flush_file();
        file_beat_t beat;
        for (int i = 0; i < fbody.size(); i++) begin
            beat.data = fbody[i];
            beat.last = (i == fbody.size() - 1);
            pending.insert(pending.size(), beat);
            n_queued++;
        end
        fbody.delete();
    endfunction

    function automatic void close_file(input bit sum_ok);
        logic [31:0] s;
        s = 32'd0;
        foreach (fbody[i]) s += {24'd0, fbody[i]};
        if (!sum_ok) s ^= 32'd1 << $urandom_range(31);
        put_le32(s);
        flush_file();
    endfunction

    function automatic int pick_count();
        int top;
        if (rec_limit == 0) return 0;
        top = (rec_limit < 4) ? rec_limit : 4;
        return $urandom_range(top, ($urandom_range(7) == 0) ? 0 : 1);
    endfunction

    function automatic void gen_file();
        int          kind;
        int          nrec;
        int          sel;
        int          cut;
        logic [31:0] cnt;
        kind = $urandom_range(99);
        nrec = pick_count();
        if (kind < 55) begin
            put_header(exp_magic, exp_version, 32'(nrec));
            repeat (nrec) put_record();
            // trailing bytes past the last record are ignored
            if ($urandom_range(4) == 0) put_noise($urandom_range(12, 1));
            close_file($urandom_range(9) != 0);
        end else if (kind < 61) begin
            put_header(exp_magic ^ (32'd1 << $urandom_range(31)), exp_version, 32'(nrec));
            repeat (nrec) put_record();
            close_file(1'b1);
        end else if (kind < 66) begin
            put_header(exp_magic, exp_version ^ (8'd1 << $urandom_range(7)), 32'(nrec));
            repeat (nrec) put_record();
            close_file(1'b1);
        end else if (kind < 72) begin
            cnt = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                           : {16'd0, rec_limit} + 32'($urandom_range(4, 1));
            put_header(exp_magic, exp_version, cnt);
            put_noise($urandom_range(20));
            close_file(1'b1);
        end else if (kind < 77) begin
            put_header(exp_magic, exp_version, 32'd0);
            put_noise($urandom_range(16));
            close_file($urandom_range(1) != 0);
        end else if (kind < 88) begin
            sel = $urandom_range(2);
            if (sel == 1 && rec_limit <= nrec) sel = 0;
            if (sel == 2 && rec_limit == 0) sel = 0;
            case (sel)
                0: begin
                    put_header(exp_magic, exp_version, 32'(nrec));
                    repeat (nrec) put_record();
                    cut = $urandom_range(fbody.size() - 1, 1);
                    fbody = fbody[0:cut-1];
                end
                1: begin
                    // count promises one more record than is present
                    put_header(exp_magic, exp_version, 32'(nrec + 1));
                    repeat (nrec) put_record();
                end
                default: begin
                    // name length that runs far past the end of the file
                    put_header(exp_magic, exp_version, 32'd1);
                    put_noise(4);
                    put_le32($urandom | 32'h0000_0100);
                    put_noise($urandom_range(30));
                end
            endcase
            close_file(1'b1);
        end else if (kind < 94) begin
            put_noise($urandom_range(4, 1));
            flush_file();
        end else begin
            put_noise($urandom_range(40, 5));
            close_file($urandom_range(1) != 0);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MAGIC:   exp_magic   = val;
            CFG_VERSION: exp_version = val[7:0];
            CFG_MAX_REC: rec_limit   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (n_in_acc != n_queued || release_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // ---------------- sequence ----------------
    initial begin
        int unsigned goal;
        clear_parser();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // short files, then the smallest well-formed one
        append_byte(8'hFF);
        flush_file();
        put_noise(3);
        flush_file();
        append_byte(8'h00);
        append_byte(8'hFF);
        put_noise(2);
        flush_file();
        put_header(exp_magic, exp_version, 32'd0);
        close_file(1'b1);

        goal = 0;
        for (int set = 0; set < 5; set++) begin
            if (set > 0) begin
                wait_drained();
                case (set)
                    1: begin
                        write_reg(CFG_MAGIC, 32'd0);
                        write_reg(CFG_VERSION, 32'd0);
                        write_reg(CFG_MAX_REC, 32'd0);
                    end
                    2: begin
                        write_reg(CFG_MAGIC, 32'hFFFF_FFFF);
                        write_reg(CFG_VERSION, 32'hFFFF_FFFF);
                        write_reg(CFG_MAX_REC, 32'hFFFF_FFFF);
                    end
                    3: begin
                        write_reg(CFG_MAGIC, $urandom);
                        write_reg(CFG_VERSION, $urandom);
                        write_reg(CFG_MAX_REC, {16'($urandom_range(65535)),
                                                16'($urandom_range(6, 1))});
                    end
                    default: begin
                        write_reg(CFG_MAGIC, MAGIC_RST);
                        write_reg(CFG_VERSION, {24'd0, VERSION_RST});
                        write_reg(CFG_MAX_REC, {16'd0, MAX_REC_RST});
                    end
                endcase
            end
            goal += ITEMS_PER_SET;
            while (n_queued < goal) gen_file();
        end

        wait_drained();
        if (n_err == 0)
            $display("tb_record_file_parse_verify_top: clean");
        else
            $display("tb_record_file_parse_verify_top: errors");
        $finish;
    end

    // both sides run without gaps over this window
    wire calm = (n_in_acc >= 900) && (n_in_acc < 1200);

    // ---------------- request driver ----------------
    always @(negedge aclk) begin
        file_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
                beat = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= beat.data;
                s_tlast  <= beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- result ready ----------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && n_in_acc >= 400) begin
            // long back-pressure while the sender keeps offering bytes
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 9);
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        release_t r;
        release_t e;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                predict_release(s_tdata, s_tlast, r);
                release_q.insert(release_q.size(), r);
                n_in_acc++;
            end
            if (m_tvalid && m_tready) begin
                if (release_q.size() == 0) begin
                    if (n_err < 10)
                        $display("unexpected result: tdata %016x tuser %0d tlast %0b",
                                 m_tdata, m_tuser, m_tlast);
                    n_err++;
                end else begin
                    e = release_q.pop_front();
                    if (m_tuser !== e.role || m_tdata[7:0] !== e.data ||
                        m_tdata[23:8] !== e.recno || m_tdata[25:24] !== e.status ||
                        m_tdata[26] !== e.match || m_tdata[58:27] !== e.sum ||
                        m_tdata[63:59] !== 5'd0 || m_tlast !== e.done) begin
                        if (n_err < 10)
                            $display({"mismatch: exp role %0d byte %02x rec %0d done %0b ",
                                      "st %0d match %0b sum %08x | got role %0d byte %02x ",
                                      "rec %0d done %0b st %0d match %0b sum %08x pad %0d"},
                                     e.role, e.data, e.recno, e.done, e.status, e.match,
                                     e.sum, m_tuser, m_tdata[7:0], m_tdata[23:8], m_tlast,
                                     m_tdata[25:24], m_tdata[26], m_tdata[58:27],
                                     m_tdata[63:59]);
                        n_err++;
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= WATCHDOG_LIMIT) begin
            $display("tb_record_file_parse_verify_top: errors");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

endmodule
